@@ design/apq_pkg.sv @@
`default_nettype none
package apq_pkg;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	// value returned by a remove on an empty queue
	localparam logic [31:0] VAL_UNDERFLOW = 32'hFFFF_FFFF;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SHIFT,
		ST_INS_PUT,
		ST_REM_READ,
		ST_RESULT
	} apq_state_t;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		logic [1:0]  status;
		logic        empty;
		logic        full;
	} apq_res_t;

endpackage
`default_nettype wire

@@ design/apq_ram.sv @@
`default_nettype none
module apq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/apq_seq.sv @@
`default_nettype none
module apq_seq #(
	parameter int DEPTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire              req_type,
	input  wire  [31:0]      value_in,
	input  wire              res_free,
	output apq_pkg::apq_res_t res
);
	import apq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	apq_state_t     state_q, state_d;
	logic [AW-1:0]  head_q, head_d;
	logic [AW-1:0]  tail_q, tail_d;
	logic [AW-1:0]  k_q, k_d;
	logic [31:0]    x_q, x_d;
	logic [31:0]    val_q, val_d;
	logic [1:0]     stat_q, stat_d;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [31:0]    wdata, rdata;

	// circular index step up and down
	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	apq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// state and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		k_q    <= k_d;
		x_q    <= x_d;
		val_q  <= val_d;
		stat_q <= stat_d;
	end

	// sequencer: insert walks down from the new tail, moving larger entries
	// up one slot with one compare per cycle, and drops the item in the gap
	always_comb begin
		logic [AW-1:0] new_tail;
		logic [AW-1:0] k_dn;

		new_tail = nxt(tail_q);
		k_dn     = prv(k_q);

		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		k_d      = k_q;
		x_d      = x_q;
		val_d    = val_q;
		stat_d   = stat_q;
		we       = 1'b0;
		waddr    = k_q;
		wdata    = x_q;
		raddr    = k_dn;
		in_stall = 1'b1;

		res.valid  = 1'b0;
		res.value  = val_q;
		res.status = stat_q;
		res.empty  = (head_q == tail_q);
		res.full   = (head_q == new_tail);

		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					x_d = value_in;
					if (req_type == REQ_INSERT) begin
						val_d = '0;
						if (head_q == new_tail) begin
							stat_d  = STAT_OVERFLOW;
							state_d = ST_RESULT;
						end else begin
							stat_d = STAT_OK;
							tail_d = new_tail;
							k_d    = new_tail;
							if (new_tail == nxt(head_q)) begin
								// queue was empty: store straight away
								we      = 1'b1;
								waddr   = new_tail;
								wdata   = value_in;
								state_d = ST_RESULT;
							end else begin
								raddr   = prv(new_tail);
								state_d = ST_INS_SHIFT;
							end
						end
					end else begin
						if (head_q == tail_q) begin
							val_d   = VAL_UNDERFLOW;
							stat_d  = STAT_UNDERFLOW;
							state_d = ST_RESULT;
						end else begin
							stat_d  = STAT_OK;
							head_d  = nxt(head_q);
							raddr   = nxt(head_q);
							state_d = ST_REM_READ;
						end
					end
				end
			end

			ST_INS_SHIFT: begin
				we = 1'b1;
				if ($signed(rdata) > $signed(x_q)) begin
					// entry below is larger: move it up, read the next one
					wdata = rdata;
					k_d   = k_dn;
					raddr = prv(k_dn);
					if (k_dn == nxt(head_q)) begin
						state_d = ST_INS_PUT;
					end
				end else begin
					state_d = ST_RESULT;
				end
			end

			ST_INS_PUT: begin
				we      = 1'b1;
				state_d = ST_RESULT;
			end

			ST_REM_READ: begin
				val_d   = rdata;
				state_d = ST_RESULT;
			end

			ST_RESULT: begin
				res.valid = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/ascending_priority_queue.sv @@
`default_nettype none
// Sorted priority queue of signed 32-bit values held ascending in a circular
// RAM of DEPTH slots (DEPTH-1 usable). One request is worked at a time; in_stall
// is high from acceptance until its result has moved into the output register,
// and the next request can be taken on the edge after that. A remove passes
// through ST_REM_READ to ST_RESULT before out_valid rises. An insert moves each
// stored entry larger than the new value up one slot, then puts the new value
// in the gap. The single comparator and the RAM's one read and one write port
// move one entry a cycle. Overflow, underflow and an insert into an empty queue
// go from ST_IDLE straight to ST_RESULT. Equal values leave in arrival order.
// The next request is taken while a result waits at the output.
module ascending_priority_queue #(
	parameter int DEPTH = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         req_type,
	input  wire  [31:0] value_in,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] value_out,
	output logic [1:0]  status,
	output logic        is_empty_now,
	output logic        is_full_now
);
	import apq_pkg::*;

	apq_res_t res;
	logic     res_free;

	apq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.value_in (value_in),
		.res_free (res_free),
		.res      (res)
	);

	// output register frees when empty or being taken this cycle
	assign res_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_free) begin
			out_valid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_free) begin
			value_out    <= res.value;
			status       <= res.status;
			is_empty_now <= res.empty;
			is_full_now  <= res.full;
		end
	end

endmodule
`default_nettype wire
